>>> rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Plain condition checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, cond) \
    label: assert property (@(posedge clk) (cond)) else $error("assertion failed");
`endif

>>> rtl/x86d_pkg.sv
// Package for the 8086 instruction decoder: mnemonic codes, status codes
// and the decoded result type. No dependencies.
package x86d_pkg;
    localparam int AddrW = 16;
    localparam int WinW  = 48;

    localparam logic [4:0] MN_UNKNOWN  = 5'd0;
    localparam logic [4:0] MN_ADD_RM   = 5'd1;
    localparam logic [4:0] MN_OR_RM    = 5'd2;
    localparam logic [4:0] MN_SBB_RM   = 5'd3;
    localparam logic [4:0] MN_AND_RM   = 5'd4;
    localparam logic [4:0] MN_XOR_RM   = 5'd5;
    localparam logic [4:0] MN_DEC      = 5'd6;
    localparam logic [4:0] MN_PUSH     = 5'd7;
    localparam logic [4:0] MN_POP      = 5'd8;
    localparam logic [4:0] MN_JNB      = 5'd9;
    localparam logic [4:0] MN_JE       = 5'd10;
    localparam logic [4:0] MN_JNE      = 5'd11;
    localparam logic [4:0] MN_JL       = 5'd12;
    localparam logic [4:0] MN_JNL      = 5'd13;
    localparam logic [4:0] MN_ADD_IMM  = 5'd14;
    localparam logic [4:0] MN_SUB_IMM  = 5'd15;
    localparam logic [4:0] MN_CMP_IMM  = 5'd16;
    localparam logic [4:0] MN_MOV_RM   = 5'd17;
    localparam logic [4:0] MN_LEA      = 5'd18;
    localparam logic [4:0] MN_MOV_IMM  = 5'd19;
    localparam logic [4:0] MN_RET      = 5'd20;
    localparam logic [4:0] MN_INT      = 5'd21;
    localparam logic [4:0] MN_SHL_1    = 5'd22;
    localparam logic [4:0] MN_SHL_CL   = 5'd23;
    localparam logic [4:0] MN_CALL     = 5'd24;
    localparam logic [4:0] MN_JMP      = 5'd25;
    localparam logic [4:0] MN_IN       = 5'd26;
    localparam logic [4:0] MN_HLT      = 5'd27;
    localparam logic [4:0] MN_TEST     = 5'd28;
    localparam logic [4:0] MN_NOT      = 5'd29;
    localparam logic [4:0] MN_NEG      = 5'd30;
    localparam logic [4:0] MN_CALL_IND = 5'd31;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [4:0]  mnemonic;
        logic [2:0]  length;
        logic        wide;
        logic        direction;
        logic [1:0]  mode_field;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [15:0] target;
        logic [1:0]  status;
    } t_result;

    function automatic logic [15:0] sext8(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction
endpackage

>>> rtl/x86d_core.sv
// Combinational decode of one 8086 instruction window.
// Depends on x86d_pkg.
module x86d_core import x86d_pkg::*; (
    input  logic [15:0] i_address,
    input  logic [47:0] i_window,
    input  logic [2:0]  i_available,
    output t_result     o_result
);
    logic [7:0]  b [0:7];
    logic [7:0]  op;
    logic [1:0]  md;
    logic [2:0]  rg;
    logic [2:0]  rmf;
    logic [15:0] ea_disp;
    logic [2:0]  ea_len;
    logic [2:0]  avail;
    logic [15:0] rel_ofs;
    logic [2:0]  rel_len;
    logic        is_rel;
    t_result     d;

    always_comb begin
        for (int i = 0; i < 6; i++) b[i] = i_window[8*i +: 8];
        b[6] = 8'h00;
        b[7] = 8'h00;
    end

    assign op  = b[0];
    assign md  = b[1][7:6];
    assign rg  = b[1][5:3];
    assign rmf = b[1][2:0];

    // Effective-address displacement and the length through it.
    always_comb begin
        if ((md == 2'b00 && rmf == 3'b110) || md == 2'b10) begin
            ea_disp = {b[3], b[2]};
            ea_len  = 3'd4;
        end else if (md == 2'b01) begin
            ea_disp = sext8(b[2]);
            ea_len  = 3'd3;
        end else begin
            ea_disp = 16'h0000;
            ea_len  = 3'd2;
        end
    end

    always_comb begin
        d          = '0;
        d.length   = 3'd1;
        is_rel     = 1'b0;
        rel_ofs    = 16'h0000;
        rel_len    = 3'd2;
        if (op <= 8'h03 || (op >= 8'h08 && op <= 8'h0B) || (op >= 8'h18 && op <= 8'h1B)
            || (op >= 8'h20 && op <= 8'h23) || (op >= 8'h30 && op <= 8'h33)
            || (op >= 8'h88 && op <= 8'h8B)) begin
            d.mode_field = md; d.reg_field = rg; d.rm_field = rmf;
            d.displacement = ea_disp; d.length = ea_len;
            d.wide = op[0]; d.direction = op[1];
            unique case (op[7:2])
                6'h00:   d.mnemonic = MN_ADD_RM;
                6'h02:   d.mnemonic = MN_OR_RM;
                6'h06:   d.mnemonic = MN_SBB_RM;
                6'h08:   d.mnemonic = MN_AND_RM;
                6'h0C:   d.mnemonic = MN_XOR_RM;
                default: d.mnemonic = MN_MOV_RM;
            endcase
        end else if (op[7:3] == 5'h09 || op[7:3] == 5'h0A || op[7:3] == 5'h0B) begin
            d.mnemonic  = (op[7:3] == 5'h09) ? MN_DEC : (op[7:3] == 5'h0A) ? MN_PUSH : MN_POP;
            d.reg_field = op[2:0];
            d.wide      = 1'b1;
        end else if (op == 8'h73 || op == 8'h74 || op == 8'h75 || op == 8'h7C || op == 8'h7D) begin
            unique case (op)
                8'h73:   d.mnemonic = MN_JNB;
                8'h74:   d.mnemonic = MN_JE;
                8'h75:   d.mnemonic = MN_JNE;
                8'h7C:   d.mnemonic = MN_JL;
                default: d.mnemonic = MN_JNL;
            endcase
            d.length = 3'd2;
            is_rel = 1'b1; rel_ofs = sext8(b[1]); rel_len = 3'd2;
        end else if (op >= 8'h80 && op <= 8'h83) begin
            d.mode_field = md; d.reg_field = rg; d.rm_field = rmf;
            d.displacement = ea_disp; d.wide = op[0];
            d.mnemonic = (rg == 3'd0) ? MN_ADD_IMM : (rg == 3'd5) ? MN_SUB_IMM
                       : (rg == 3'd7) ? MN_CMP_IMM : MN_UNKNOWN;
            if (op == 8'h81) begin
                d.immediate = {b[ea_len + 3'd1], b[ea_len]};
                d.length    = ea_len + 3'd2;
            end else begin
                d.immediate = (op == 8'h83) ? sext8(b[ea_len]) : {8'h00, b[ea_len]};
                d.length    = ea_len + 3'd1;
            end
        end else if (op == 8'h8D) begin
            d.mode_field = md; d.reg_field = rg; d.rm_field = rmf;
            d.displacement = ea_disp; d.length = ea_len;
            d.mnemonic = MN_LEA; d.wide = 1'b1; d.direction = 1'b1;
        end else if (op[7:4] == 4'hB) begin
            d.mnemonic  = MN_MOV_IMM;
            d.wide      = op[3];
            d.reg_field = op[2:0];
            d.immediate = op[3] ? {b[2], b[1]} : {8'h00, b[1]};
            d.length    = op[3] ? 3'd3 : 3'd2;
        end else if (op == 8'hC3) begin
            d.mnemonic = MN_RET;
        end else if (op == 8'hCC) begin
            d.mnemonic = MN_INT; d.immediate = 16'd3;
        end else if (op == 8'hCD) begin
            d.mnemonic = MN_INT; d.immediate = {8'h00, b[1]}; d.length = 3'd2;
        end else if (op >= 8'hD0 && op <= 8'hD3) begin
            d.mode_field = md; d.reg_field = rg; d.rm_field = rmf;
            d.displacement = ea_disp; d.length = ea_len; d.wide = op[0];
            d.mnemonic = (rg == 3'd4) ? (op[1] ? MN_SHL_CL : MN_SHL_1) : MN_UNKNOWN;
        end else if (op == 8'hE8 || op == 8'hE9) begin
            d.mnemonic = op[0] ? MN_JMP : MN_CALL;
            d.length = 3'd3;
            is_rel = 1'b1; rel_ofs = {b[2], b[1]}; rel_len = 3'd3;
        end else if (op == 8'hEB) begin
            d.mnemonic = MN_JMP; d.length = 3'd2;
            is_rel = 1'b1; rel_ofs = sext8(b[1]); rel_len = 3'd2;
        end else if (op == 8'hE4 || op == 8'hE5) begin
            d.mnemonic = MN_IN; d.wide = op[0];
            d.immediate = {8'h00, b[1]}; d.length = 3'd2;
        end else if (op == 8'hEC || op == 8'hED) begin
            d.mnemonic = MN_IN; d.wide = op[0];
        end else if (op == 8'hF4) begin
            d.mnemonic = MN_HLT;
        end else if (op == 8'hF6 || op == 8'hF7) begin
            d.mode_field = md; d.reg_field = rg; d.rm_field = rmf;
            d.displacement = ea_disp; d.length = ea_len; d.wide = op[0];
            if (rg == 3'd0) begin
                d.mnemonic  = MN_TEST;
                d.immediate = op[0] ? {b[ea_len + 3'd1], b[ea_len]} : {8'h00, b[ea_len]};
                d.length    = ea_len + 3'd1 + {2'b00, op[0]};
            end else begin
                d.mnemonic = (rg == 3'd2) ? MN_NOT : (rg == 3'd3) ? MN_NEG : MN_UNKNOWN;
            end
        end else if (op == 8'hFF) begin
            d.mode_field = md; d.reg_field = rg; d.rm_field = rmf;
            d.displacement = ea_disp; d.length = ea_len; d.wide = 1'b1;
            d.mnemonic = (rg == 3'd2) ? MN_CALL_IND : (rg == 3'd6) ? MN_PUSH : MN_UNKNOWN;
        end
        if (is_rel) d.target = i_address + {13'd0, rel_len} + rel_ofs;
    end

    assign avail = (i_available == 3'd7) ? 3'd6 : i_available;

    always_comb begin
        o_result = d;
        if (d.mnemonic == MN_UNKNOWN) begin
            o_result        = '0;
            o_result.length = 3'd1;
            o_result.status = ST_UNKNOWN;
        end else if (d.length > avail) begin
            o_result.status = ST_TRUNCATED;
        end
    end
endmodule

>>> rtl/x86d_skid.sv
// Two-entry output buffer that decouples the decoder from a stalling sink.
// Depends on x86d_pkg.
module x86d_skid import x86d_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);
    logic    r_valid, r_skid_valid;
    t_result r_data, r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // While the skid entry is full the input is not taken; the entry drains
    // into the output register first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_valid || i_ready) begin
                if (r_skid_valid) begin
                    r_valid      <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_valid <= i_valid;
                end
            end else if (i_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || i_ready) begin
            r_data <= r_skid_valid ? r_skid : i_data;
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end
endmodule

>>> rtl/x86_16_instruction_decoder.sv
// Top level of the 8086 instruction pre-decoder: input register, decode
// logic and output buffer. Depends on x86d_pkg, x86d_core, x86d_skid.
//
// Usage: the slave channel carries one word per instruction: the address,
// a six-byte window (first byte lowest) and the count of valid bytes.
// The master channel returns one decoded word per input word, in order.
// Each input word is latched into an input register, decoded by one pass
// of combinational logic, and written into a two-entry output buffer.
// The word passes through the input register and the buffer's output register before m_axis_tvalid.
// Throughput is one word per cycle while the sink keeps tready high; the
// output buffer lets the block keep accepting while a result waits.
// When the sink stalls, the buffer fills and s_axis_tready falls after at
// most two more words; nothing is lost or repeated.
// Synchronous reset empties the input register and the buffer; there is
// no other state, so the first word may arrive right after reset.
// Status codes: 0 ok, 1 unknown form, 2 truncated.
`include "assert_macros.svh"
module x86_16_instruction_decoder import x86d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address[15:0], window[63:16], available[66:64], zeros to bit 71
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mnemonic[4:0], length[7:5], wide[8], direction[9], mode_field[11:10],
    // reg_field[14:12], rm_field[17:15], displacement[33:18],
    // immediate[49:34], target[65:50], status[67:66], zeros to bit 71
    output logic [71:0] m_axis_tdata
);
    logic        r_in_valid;
    logic [15:0] r_address;
    logic [47:0] r_window;
    logic [2:0]  r_available;
    logic        buf_ready;
    t_result     dec, out;

    // The input register advances whenever the buffer can take its word or the register is empty.
    assign s_axis_tready = buf_ready || !r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_address   <= s_axis_tdata[15:0];
            r_window    <= s_axis_tdata[63:16];
            r_available <= s_axis_tdata[66:64];
        end
    end

    x86d_core u_core (
        .i_address   (r_address),
        .i_window    (r_window),
        .i_available (r_available),
        .o_result    (dec)
    );

    x86d_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (buf_ready),
        .i_data  (dec),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out)
    );

    assign m_axis_tdata = {4'h0, out.status, out.target, out.immediate, out.displacement,
                           out.rm_field, out.reg_field, out.mode_field, out.direction,
                           out.wide, out.length, out.mnemonic};

    `ASSERT_IMPL(a_len_range, i_clk, i_rst_n,
        !m_axis_tvalid || (out.length >= 3'd1 && out.length <= 3'd6))
    `ASSERT_IMPL(a_unknown_len, i_clk, i_rst_n,
        !m_axis_tvalid || out.status != ST_UNKNOWN
        || (out.length == 3'd1 && out.mnemonic == MN_UNKNOWN))
    `ASSERT_IMPL(a_out_hold, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
endmodule

>>> tb/sv/tb_x86_16_instruction_decoder.sv
// Self-checking testbench for the 8086 instruction pre-decoder.
// Drives instruction windows on the slave stream and checks decoded words; needs x86d_pkg.
`timescale 1ns / 100ps
module tb_x86_16_instruction_decoder;
    import x86d_pkg::*;

    typedef struct {
        logic [15:0] address;
        logic [47:0] window;
        logic [2:0]  available;
    } t_instr;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // address[15:0], window[63:16], available[66:64], zeros to bit 71
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // mnemonic[4:0], length[7:5], wide[8], direction[9], mode_field[11:10],
    // reg_field[14:12], rm_field[17:15], displacement[33:18],
    // immediate[49:34], target[65:50], status[67:66], zeros to bit 71
    logic [71:0] m_axis_tdata;

    x86_16_instruction_decoder dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_instr  pending_instrs[$];
    t_result expected_decodes[$];
    int      send_idle_pct = 0;
    int      sink_stall_pct = 0;
    int      error_count = 0;
    int      decode_count = 0;
    longint  cycle_count = 0;
    bit      in_taken = 1'b0;
    int      mnemonic_seen[32];

    function automatic logic [15:0] sign_byte(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

    // Predicts the decoded word for one instruction window.
    function automatic t_result decode_instr(input t_instr it);
        t_result r;
        logic [7:0] b[8];
        logic [7:0] op;
        int avail;
        for (int i = 0; i < 8; i++) b[i] = (i < 6) ? it.window[8*i +: 8] : 8'h00;
        avail = (it.available > 6) ? 6 : it.available;
        op = b[0];
        r = '0;
        r.length = 3'd1;
        // Any ModRM form: fields, displacement and length up to the displacement.
        if (op <= 8'h03 || (op >= 8'h08 && op <= 8'h0B) || (op >= 8'h18 && op <= 8'h1B) ||
            (op >= 8'h20 && op <= 8'h23) || (op >= 8'h30 && op <= 8'h33) ||
            (op >= 8'h80 && op <= 8'h8B) || op == 8'h8D || (op >= 8'hD0 && op <= 8'hD3) ||
            op == 8'hF6 || op == 8'hF7 || op == 8'hFF) begin
            r.mode_field = b[1][7:6];
            r.reg_field = b[1][5:3];
            r.rm_field = b[1][2:0];
            if ((r.mode_field == 2'b00 && r.rm_field == 3'b110) || r.mode_field == 2'b10) begin
                r.displacement = {b[3], b[2]};
                r.length = 3'd4;
            end else if (r.mode_field == 2'b01) begin
                r.displacement = sign_byte(b[2]);
                r.length = 3'd3;
            end else begin
                r.length = 3'd2;
            end
        end
        if (op <= 8'h03 || (op >= 8'h08 && op <= 8'h0B) || (op >= 8'h18 && op <= 8'h1B) ||
            (op >= 8'h20 && op <= 8'h23) || (op >= 8'h30 && op <= 8'h33) ||
            (op >= 8'h88 && op <= 8'h8B)) begin
            r.mnemonic = (op <= 8'h03) ? MN_ADD_RM : (op <= 8'h0B) ? MN_OR_RM :
                         (op <= 8'h1B) ? MN_SBB_RM : (op <= 8'h23) ? MN_AND_RM :
                         (op <= 8'h33) ? MN_XOR_RM : MN_MOV_RM;
            r.wide = op[0];
            r.direction = op[1];
        end else if (op[7:3] == 5'b01001 || op[7:3] == 5'b01010 || op[7:3] == 5'b01011) begin
            r.mnemonic = (op[7:3] == 5'b01001) ? MN_DEC : (op[7:3] == 5'b01010) ? MN_PUSH : MN_POP;
            r.reg_field = op[2:0];
            r.wide = 1'b1;
        end else if (op == 8'h73 || op == 8'h74 || op == 8'h75 || op == 8'h7C || op == 8'h7D) begin
            r.mnemonic = (op == 8'h73) ? MN_JNB : (op == 8'h74) ? MN_JE : (op == 8'h75) ? MN_JNE :
                         (op == 8'h7C) ? MN_JL : MN_JNL;
            r.length = 3'd2;
            r.target = it.address + 16'd2 + sign_byte(b[1]);
        end else if (op >= 8'h80 && op <= 8'h83) begin
            r.wide = op[0];
            r.mnemonic = (r.reg_field == 3'd0) ? MN_ADD_IMM : (r.reg_field == 3'd5) ? MN_SUB_IMM :
                         (r.reg_field == 3'd7) ? MN_CMP_IMM : MN_UNKNOWN;
            // Immediate sits after the displacement; 0x81 is a word, 0x83 a signed byte.
            if (op == 8'h81) begin
                r.immediate = {b[(r.length + 1) & 7], b[r.length & 7]};
                r.length += 3'd2;
            end else begin
                r.immediate = (op == 8'h83) ? sign_byte(b[r.length & 7]) : {8'h00, b[r.length & 7]};
                r.length += 3'd1;
            end
        end else if (op == 8'h8D) begin
            r.mnemonic = MN_LEA;
            r.wide = 1'b1;
            r.direction = 1'b1;
        end else if (op[7:4] == 4'hB) begin
            r.mnemonic = MN_MOV_IMM;
            r.wide = op[3];
            r.reg_field = op[2:0];
            r.immediate = r.wide ? {b[2], b[1]} : {8'h00, b[1]};
            r.length = r.wide ? 3'd3 : 3'd2;
        end else if (op == 8'hC3) begin
            r.mnemonic = MN_RET;
        end else if (op == 8'hCC) begin
            r.mnemonic = MN_INT;
            r.immediate = 16'd3;
        end else if (op == 8'hCD) begin
            r.mnemonic = MN_INT;
            r.immediate = {8'h00, b[1]};
            r.length = 3'd2;
        end else if (op >= 8'hD0 && op <= 8'hD3) begin
            r.wide = op[0];
            r.mnemonic = (r.reg_field != 3'd4) ? MN_UNKNOWN : op[1] ? MN_SHL_CL : MN_SHL_1;
        end else if (op == 8'hE8 || op == 8'hE9) begin
            r.mnemonic = (op == 8'hE8) ? MN_CALL : MN_JMP;
            r.length = 3'd3;
            r.target = it.address + 16'd3 + {b[2], b[1]};
        end else if (op == 8'hEB) begin
            r.mnemonic = MN_JMP;
            r.length = 3'd2;
            r.target = it.address + 16'd2 + sign_byte(b[1]);
        end else if (op == 8'hE4 || op == 8'hE5) begin
            r.mnemonic = MN_IN;
            r.wide = op[0];
            r.immediate = {8'h00, b[1]};
            r.length = 3'd2;
        end else if (op == 8'hEC || op == 8'hED) begin
            r.mnemonic = MN_IN;
            r.wide = op[0];
        end else if (op == 8'hF4) begin
            r.mnemonic = MN_HLT;
        end else if (op == 8'hF6 || op == 8'hF7) begin
            r.wide = op[0];
            if (r.reg_field == 3'd0) begin
                r.mnemonic = MN_TEST;
                r.immediate = r.wide ? {b[(r.length + 1) & 7], b[r.length & 7]}
                                     : {8'h00, b[r.length & 7]};
                r.length += r.wide ? 3'd2 : 3'd1;
            end else begin
                r.mnemonic = (r.reg_field == 3'd2) ? MN_NOT :
                             (r.reg_field == 3'd3) ? MN_NEG : MN_UNKNOWN;
            end
        end else if (op == 8'hFF) begin
            r.wide = 1'b1;
            r.mnemonic = (r.reg_field == 3'd2) ? MN_CALL_IND :
                         (r.reg_field == 3'd6) ? MN_PUSH : MN_UNKNOWN;
        end
        if (r.mnemonic == MN_UNKNOWN) begin
            r = '0;
            r.length = 3'd1;
            r.status = ST_UNKNOWN;
        end else if (r.length > avail) begin
            r.status = ST_TRUNCATED;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("decode %0d: %s is 0x%0h, expected 0x%0h", decode_count, field, got, want);
        error_count++;
    endtask

    // Driver: a word moves at a rising edge with valid and ready high, so a
    // new word is put up only when the last one was taken or none is waiting.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (pending_instrs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_instr it;
                it = pending_instrs.pop_front();
                s_axis_tdata <= {5'd0, it.available, it.window, it.address};
                s_axis_tvalid <= 1'b1;
                expected_decodes.push_back(decode_instr(it));
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor: compares each accepted decoded word with the oldest prediction.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_result got, want;
            got.mnemonic     = m_axis_tdata[4:0];
            got.length       = m_axis_tdata[7:5];
            got.wide         = m_axis_tdata[8];
            got.direction    = m_axis_tdata[9];
            got.mode_field   = m_axis_tdata[11:10];
            got.reg_field    = m_axis_tdata[14:12];
            got.rm_field     = m_axis_tdata[17:15];
            got.displacement = m_axis_tdata[33:18];
            got.immediate    = m_axis_tdata[49:34];
            got.target       = m_axis_tdata[65:50];
            got.status       = m_axis_tdata[67:66];
            if (expected_decodes.size() == 0) begin
                $display("decoded word with no instruction outstanding");
                error_count++;
            end else begin
                want = expected_decodes.pop_front();
                mnemonic_seen[want.mnemonic]++;
                if (got.mnemonic !== want.mnemonic)
                    report_mismatch("mnemonic", got.mnemonic, want.mnemonic);
                if (got.length !== want.length)
                    report_mismatch("length", got.length, want.length);
                if (got.wide !== want.wide) report_mismatch("wide", got.wide, want.wide);
                if (got.direction !== want.direction)
                    report_mismatch("direction", got.direction, want.direction);
                if (got.mode_field !== want.mode_field)
                    report_mismatch("mode_field", got.mode_field, want.mode_field);
                if (got.reg_field !== want.reg_field)
                    report_mismatch("reg_field", got.reg_field, want.reg_field);
                if (got.rm_field !== want.rm_field)
                    report_mismatch("rm_field", got.rm_field, want.rm_field);
                if (got.displacement !== want.displacement)
                    report_mismatch("displacement", got.displacement, want.displacement);
                if (got.immediate !== want.immediate)
                    report_mismatch("immediate", got.immediate, want.immediate);
                if (got.target !== want.target)
                    report_mismatch("target", got.target, want.target);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
            decode_count++;
        end
    end

    // Watchdog for the 1675 words in all: ends the run as failed on timeout.
    always @(posedge i_clk) begin
        if (cycle_count > 400000) begin
            $display("timeout with %0d decodes outstanding", expected_decodes.size());
            $display("x86_16_instruction_decoder test failed");
            $finish;
        end
    end

    // Opcodes of the recognized forms, used to bias the random windows.
    localparam logic [7:0] KnownOps[40] = '{
        8'h00, 8'h03, 8'h09, 8'h1A, 8'h21, 8'h32, 8'h4B, 8'h55, 8'h5F, 8'h73,
        8'h74, 8'h75, 8'h7C, 8'h7D, 8'h80, 8'h81, 8'h82, 8'h83, 8'h88, 8'h8B,
        8'h8D, 8'hB2, 8'hBC, 8'hC3, 8'hCC, 8'hCD, 8'hD0, 8'hD1, 8'hD2, 8'hD3,
        8'hE8, 8'hE9, 8'hEB, 8'hE4, 8'hED, 8'hF4, 8'hF6, 8'hF7, 8'hFF, 8'h8A};

    task automatic add_instr(input logic [15:0] a, input logic [47:0] w, input logic [2:0] n);
        t_instr it;
        it.address = a;
        it.window = w;
        it.available = n;
        pending_instrs.push_back(it);
    endtask

    function automatic logic [47:0] random_window();
        return {$urandom, 16'($urandom)};
    endfunction

    task automatic run_phase(input int send_pct, input int stall_pct, input int count);
        logic [47:0] w;
        logic [2:0] n;
        send_idle_pct = send_pct;
        sink_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            w = random_window();
            // Mostly recognized opcodes, with a reg field chosen anew for half of them.
            if ($urandom_range(99) < 80) begin
                w[7:0] = KnownOps[$urandom_range(39)];
                if ($urandom_range(1)) w[13:11] = 3'($urandom_range(7));
            end
            n = ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(6, 4));
            add_instr(16'($urandom), w, n);
        end
        while (pending_instrs.size() != 0 || expected_decodes.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: many of the forms, an unknown opcode, branches across the address wrap, truncation
        // and the out-of-range byte counts, ModRM displacement kinds.
        add_instr(16'hFFFF, 48'h0000_0000_FF00, 3'd6);
        add_instr(16'h0000, 48'h0000_0000_FF73, 3'd2);
        add_instr(16'hFFFE, 48'h0000_0000_7F74, 3'd7);
        add_instr(16'h1234, 48'h0000_0000_8075, 3'd0);
        add_instr(16'hFFFD, 48'h0000_00FF_FFE9, 3'd3);
        add_instr(16'h8000, 48'h0000_0080_00E8, 3'd6);
        add_instr(16'h0010, 48'h0000_0000_80EB, 3'd1);
        add_instr(16'h0000, 48'hFFFF_1234_8681, 3'd6);
        add_instr(16'h0000, 48'h0000_0080_7E83, 3'd3);
        add_instr(16'h0000, 48'h0000_0081_FF82, 3'd3);
        add_instr(16'h0000, 48'h0000_ABCD_BE80, 3'd5);
        add_instr(16'h0000, 48'h00BE_EF80_47F7, 3'd5);
        add_instr(16'h0000, 48'h0000_0012_C6F6, 3'd3);
        add_instr(16'h0000, 48'h0000_0000_D7F6, 3'd2);
        add_instr(16'h0000, 48'h0000_0000_1EF7, 3'd1);
        add_instr(16'h0000, 48'h0000_0000_E3D3, 3'd2);
        add_instr(16'h0000, 48'h0000_0000_C0D0, 3'd2);
        add_instr(16'h0000, 48'h0000_5678_16FF, 3'd4);
        add_instr(16'h0000, 48'h0000_0000_F1FF, 3'd2);
        add_instr(16'h0000, 48'h0000_0000_078D, 3'd2);
        add_instr(16'h0000, 48'h0000_00BE_EFB9, 3'd3);
        add_instr(16'h0000, 48'h0000_0000_3CCD, 3'd2);
        add_instr(16'h0000, 48'hFFFF_FFFF_FFCC, 3'd1);
        add_instr(16'h0000, 48'h0000_0000_60E4, 3'd1);
        add_instr(16'h0000, 48'h0000_0000_0010, 3'd6);
        run_phase(0, 0, 0);

        run_phase(0, 0, 420);
        run_phase(68, 0, 410);
        run_phase(0, 68, 410);
        run_phase(22, 22, 410);
        repeat (10) @(posedge i_clk);

        $display("Decoded %0d windows over four handshake pressure settings.", decode_count);
        $display("Unknown forms %0d, MOV r/m %0d, TEST %0d.", mnemonic_seen[0],
                 mnemonic_seen[17], mnemonic_seen[28]);
        if (error_count == 0 && expected_decodes.size() == 0) begin
            $display("x86_16_instruction_decoder test passed");
        end else begin
            $display("x86_16_instruction_decoder test failed");
        end
        $finish;
    end
endmodule
